// ===== rtl/assert_macros.svh =====
// shared assertion macros for the torque unit checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHECK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gtu_pkg.sv =====
// ----------------------------------------------------------------------------
// gtu_pkg
// shared types for the gyroscopic torque unit
// ----------------------------------------------------------------------------
package gtu_pkg;

   // status travelling with one axis through the divider lanes
   typedef struct packed {
      logic valid;
      logic ovf;
   } lane_stat_type;

endpackage

// ===== rtl/gtu_div_lane.sv =====
// ----------------------------------------------------------------------------
// gtu_div_lane
// pipelined restoring divider, one quotient bit per stage: momentum = w / d
// ----------------------------------------------------------------------------
module gtu_div_lane import gtu_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic signed [VALUE_WIDTH-1:0] omega,
   input  logic        [VALUE_WIDTH-1:0] inv_inertia,
   output lane_stat_type                 stat,
   output logic signed [VALUE_WIDTH-1:0] omega_out,
   output logic signed [VALUE_WIDTH-1:0] momentum
);
   localparam int NB = VALUE_WIDTH + FRAC_BITS;
   localparam int RW = VALUE_WIDTH + 1;

   logic [NB-1:0]          quo_ff  [0:NB];
   logic [RW-1:0]          rem_ff  [0:NB];
   logic [VALUE_WIDTH-1:0] div_ff  [0:NB];
   logic [VALUE_WIDTH-1:0] om_ff   [0:NB];
   logic [NB-1:0]          quo_in  [0:NB];
   logic [RW-1:0]          rem_in  [0:NB];
   logic [VALUE_WIDTH-1:0] div_in  [0:NB];
   logic [VALUE_WIDTH-1:0] om_in   [0:NB];
   logic [NB:0]            vld_ff;
   logic [NB:0]            vld_in;
   logic                   neg;
   logic [VALUE_WIDTH-1:0] mag;
   logic [NB-1:0]          dividend;
   logic [NB-1:0]          q_fin;
   logic [NB-1:0]          limit;
   logic                   zero_div;
   logic                   big;

   // stage zero: load magnitude and divisor
   always_comb begin
      neg      = omega[VALUE_WIDTH-1];
      mag      = neg ? (~omega + 1'b1) : omega;
      dividend = {mag, {FRAC_BITS{1'b0}}};
      quo_in[0] = dividend;
      rem_in[0] = '0;
      div_in[0] = inv_inertia;
      om_in[0]  = omega;
      vld_in[0] = in_valid;
      for (int s = 0; s < NB; s++) begin
         logic [RW-1:0] sh;
         logic [RW:0]   diff;
         sh   = {rem_ff[s][RW-2:0], quo_ff[s][NB-1]};
         diff = {1'b0, sh} - {2'b00, div_ff[s]};
         rem_in[s+1] = diff[RW] ? sh : diff[RW-1:0];
         quo_in[s+1] = {quo_ff[s][NB-2:0], ~diff[RW]};
         div_in[s+1] = div_ff[s];
         om_in[s+1]  = om_ff[s];
         vld_in[s+1] = vld_ff[s];
      end
   end

   // stage registers, advanced together under enable
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
      if (enable) begin
         for (int s = 0; s <= NB; s++) begin
            quo_ff[s] <= quo_in[s];
            rem_ff[s] <= rem_in[s];
            div_ff[s] <= div_in[s];
            om_ff[s]  <= om_in[s];
         end
      end
   end

   // final range check and sign
   always_comb begin
      q_fin    = quo_ff[NB];
      zero_div = (div_ff[NB] == '0);
      limit    = NB'((64'(1) << (VALUE_WIDTH-1)) - (om_ff[NB][VALUE_WIDTH-1] ? 64'd0 : 64'd1));
      big      = (q_fin > limit);
      stat.valid = vld_ff[NB];
      stat.ovf   = !zero_div && big;
      omega_out  = om_ff[NB];
      if (zero_div || big) momentum = '0;
      else if (om_ff[NB][VALUE_WIDTH-1]) momentum = VALUE_WIDTH'(~q_fin + 1'b1);
      else momentum = q_fin[VALUE_WIDTH-1:0];
   end
endmodule

// ===== rtl/gtu_cross.sv =====
// ----------------------------------------------------------------------------
// gtu_cross
// merging stage: cross product w x L with overflow checks, two stages
// ----------------------------------------------------------------------------
module gtu_cross import gtu_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic                          in_ovf,
   input  logic signed [VALUE_WIDTH-1:0] w0, w1, w2,
   input  logic signed [VALUE_WIDTH-1:0] l0, l1, l2,
   output logic                          out_valid,
   output logic signed [VALUE_WIDTH-1:0] t0, t1, t2,
   output logic                          ok
);
   localparam int PW = 2 * VALUE_WIDTH;
   localparam int DW = PW + 1;

   logic signed [PW-1:0] p_ff [0:5];
   logic signed [PW-1:0] p_in [0:5];
   logic                 v_ff, bad_ff;
   logic signed [DW-1:0] d [0:2];
   logic signed [DW-1:0] s [0:2];
   logic [2:0]           fit;

   // first stage: six products
   always_comb begin
      p_in[0] = w1 * l2;  p_in[1] = w2 * l1;
      p_in[2] = w2 * l0;  p_in[3] = w0 * l2;
      p_in[4] = w0 * l1;  p_in[5] = w1 * l0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (enable) begin
         v_ff <= in_valid;
      end
      if (enable) begin
         bad_ff <= in_ovf;
         for (int k = 0; k < 6; k++) p_ff[k] <= p_in[k];
      end
   end

   // second stage: subtract, shift, range check
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d[k]   = DW'(p_ff[2*k]) - DW'(p_ff[2*k+1]);
         s[k]   = d[k] >>> FRAC_BITS;
         fit[k] = (s[k][DW-1:VALUE_WIDTH-1] == '0) || (s[k][DW-1:VALUE_WIDTH-1] == '1);
      end
      ok        = !bad_ff && (&fit);
      out_valid = v_ff;
      t0 = ok ? s[0][VALUE_WIDTH-1:0] : '0;
      t1 = ok ? s[1][VALUE_WIDTH-1:0] : '0;
      t2 = ok ? s[2][VALUE_WIDTH-1:0] : '0;
   end
endmodule

// ===== rtl/gyroscopic_torque_unit.sv =====
// pipeline: divider lane stages, cross product register, output register
// throughput: one transaction per cycle while the output is not stalled, set by the bit-per-stage divider lanes
// the whole pipeline stalls while a result waits untaken in the output register
// reset: synchronous, clears the valid bits of every stage and the output
// ----------------------------------------------------------------------------
// gyroscopic_torque_unit
// three divider lanes form angular momentum, a cross stage forms the torque
// ----------------------------------------------------------------------------
module gyroscopic_torque_unit import gtu_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // omega_x, omega_y, omega_z, inv_inertia_x, inv_inertia_y, inv_inertia_z
   input  logic [((6*VALUE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // torque_x, torque_y, torque_z, ok, zero fill
   output logic [((3*VALUE_WIDTH+1+7)/8)*8-1:0] rsp_tdata
);
   localparam int V  = VALUE_WIDTH;
   localparam int OW = ((3*VALUE_WIDTH+1+7)/8)*8;

   logic                 enable;
   lane_stat_type        st [0:2];
   logic signed [V-1:0]  wo [0:2];
   logic signed [V-1:0]  lm [0:2];
   logic                 c_valid, c_ok;
   logic signed [V-1:0]  tx, ty, tz;
   logic                 out_v_ff;
   logic [OW-1:0]        out_d_ff;

   // pipeline advances when output register is free or being drained
   assign enable     = !out_v_ff || rsp_tready;
   assign req_tready = enable;

   // one divider lane per axis
   for (genvar g = 0; g < 3; g++) begin : g_lane
      gtu_div_lane #(.VALUE_WIDTH(V), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock), .reset(reset), .enable(enable),
         .in_valid(req_tvalid),
         .omega(req_tdata[g*V +: V]),
         .inv_inertia(req_tdata[(3+g)*V +: V]),
         .stat(st[g]), .omega_out(wo[g]), .momentum(lm[g])
      );
   end

   // merging stage
   gtu_cross #(.VALUE_WIDTH(V), .FRAC_BITS(FRAC_BITS)) u_cross (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(st[0].valid),
      .in_ovf(st[0].ovf || st[1].ovf || st[2].ovf),
      .w0(wo[0]), .w1(wo[1]), .w2(wo[2]),
      .l0(lm[0]), .l1(lm[1]), .l2(lm[2]),
      .out_valid(c_valid), .t0(tx), .t1(ty), .t2(tz), .ok(c_ok)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (enable) begin
         out_v_ff <= c_valid;
      end
      if (enable) begin
         out_d_ff <= OW'({c_ok, tz, ty, tx});
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
endmodule

// ===== rtl/gtu_checker.sv =====
// ----------------------------------------------------------------------------
// gtu_checker
// port-level checks for the gyroscopic torque unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gtu_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_tready,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready,
   input logic [((3*VALUE_WIDTH+1+7)/8)*8-1:0]   rsp_tdata
);
   localparam int V = VALUE_WIDTH;

   logic rsp_fail;
   logic rsp_zero;
   logic ready_exp;
   logic rsp_stall;

   // terms shared by the checks
   assign rsp_fail  = rsp_tvalid && !rsp_tdata[3*V];
   assign rsp_zero  = (rsp_tdata[3*V-1:0] == '0);
   assign ready_exp = !rsp_tvalid || rsp_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // a failed result carries zero torque
   `CHECK_IMPLY(a_zero_on_fail, clock, reset, rsp_fail, rsp_zero, "torque not zero when not ok")
   // ready follows the output register
   `CHECK_ALWAYS(a_ready, clock, reset, req_tready == ready_exp, "req_tready wrong")
   // stalled result holds
   `CHECK_NEXT(a_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "result changed")
endmodule

bind gyroscopic_torque_unit gtu_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_gtu_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// ===== dv/tb_gyroscopic_torque_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gyroscopic_torque_unit
// streams bodies through the torque unit and checks every torque vector
// against a bit-exact momentum and cross-product calculation
// ----------------------------------------------------------------------------

// predicted torque vectors, oldest first
class torque_scoreboard;
   localparam int VW = 32;
   localparam int FB = 16;

   typedef struct packed {
      logic [VW-1:0] tx;
      logic [VW-1:0] ty;
      logic [VW-1:0] tz;
      logic          ok;
   } torque_type;

   torque_type pending[$];
   int      n_checked;
   int      n_bad;
   int      n_ok;
   int      n_overflow;
   int      n_orphan;

   // momentum per axis, truncated toward zero; returns 0 on overflow
   function automatic bit axis_momentum(logic signed [VW-1:0] w, logic [VW-1:0] d,
                                        output logic signed [63:0] mom);
      logic [127:0] mag;
      logic [127:0] quo;
      mom = 0;
      if (d == 0) return 1;
      mag = (w < 0) ? -$signed({{32{w[VW-1]}}, w}) : w;
      quo = (mag << FB) / d;
      if (w < 0) begin
         if (quo > (128'd1 << (VW-1))) return 0;
         mom = -$signed(quo[63:0]);
      end else begin
         if (quo > ((128'd1 << (VW-1)) - 1)) return 0;
         mom = quo[63:0];
      end
      return 1;
   endfunction

   // (a*b - c*d) >>> FB, checked against the signed width
   function automatic bit cross_term(logic signed [63:0] a, logic signed [63:0] b,
                                     logic signed [63:0] c, logic signed [63:0] d,
                                     output logic [VW-1:0] res);
      logic signed [159:0] v;
      v = ($signed({{96{a[63]}}, a}) * $signed({{96{b[63]}}, b}))
        - ($signed({{96{c[63]}}, c}) * $signed({{96{d[63]}}, d}));
      v = v >>> FB;
      res = v[VW-1:0];
      return (v >= -(160'sd1 <<< (VW-1))) && (v < (160'sd1 <<< (VW-1)));
   endfunction

   function void note_body(logic [6*VW-1:0] body);
      logic signed [63:0] w[3];
      logic signed [63:0] mom[3];
      logic [VW-1:0]      t[3];
      torque_type         exp_t;
      bit                 good;
      good = 1;
      for (int k = 0; k < 3; k++) begin
         w[k] = $signed(body[k*VW +: VW]);
         if (!axis_momentum(body[k*VW +: VW], body[(3+k)*VW +: VW], mom[k])) good = 0;
      end
      if (good) begin
         if (!cross_term(w[1], mom[2], w[2], mom[1], t[0])) good = 0;
         if (!cross_term(w[2], mom[0], w[0], mom[2], t[1])) good = 0;
         if (!cross_term(w[0], mom[1], w[1], mom[0], t[2])) good = 0;
      end
      exp_t.tx = good ? t[0] : '0;
      exp_t.ty = good ? t[1] : '0;
      exp_t.tz = good ? t[2] : '0;
      exp_t.ok = good;
      if (good) n_ok++; else n_overflow++;
      pending.push_back(exp_t);
   endfunction

   function void check_torque(logic [3*VW:0] got);
      torque_type g;
      torque_type e;
      g.tx = got[0 +: VW];
      g.ty = got[VW +: VW];
      g.tz = got[2*VW +: VW];
      g.ok = got[3*VW];
      if (pending.size() == 0) begin
         n_bad++;
         n_orphan++;
         if (n_bad <= 10) $display("unexpected torque transaction %h", got);
         return;
      end
      e = pending.pop_front();
      n_checked++;
      if (g != e) begin
         n_bad++;
         if (n_bad <= 10)
            $display("torque %0d: expected x=%h y=%h z=%h ok=%b, got x=%h y=%h z=%h ok=%b",
                     n_checked, e.tx, e.ty, e.tz, e.ok, g.tx, g.ty, g.tz, g.ok);
      end
   endfunction
endclass

module tb_gyroscopic_torque_unit;
   import gtu_pkg::*;

   localparam int VW       = 32;
   localparam int LATENCY  = 2*VW + 3;
   localparam int N_RANDOM = 730;

   logic           clock = 0;
   logic           reset = 1;
   logic           req_tvalid = 0;
   logic           req_tready;
   logic [191:0]   req_tdata = '0;
   logic           rsp_tvalid;
   logic           rsp_tready = 0;
   logic [103:0]   rsp_tdata;

   torque_scoreboard sb = new();
   int  n_sent;
   bit  all_sent;
   bit  hold_off;
   bit  calm;

   gyroscopic_torque_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // note accepted transactions on both sides
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_body(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_torque(rsp_tdata[3*VW:0]);
      end
   end

   // receiver: random stalls, one long hold-off, calm stretch
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 0;
      else rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
   end

   initial begin
      hold_off = 0;
      wait (n_sent >= 200);
      @(posedge clock);
      hold_off = 1;
      repeat (300) @(posedge clock);
      hold_off = 0;
   end

   function automatic logic [31:0] rand_omega();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
         3: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_inv();
      case ($urandom_range(6))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return $urandom_range(32'h0001_0000, 32'h0040_0000);
         3: return $urandom_range(1, 32'h0000_1000);
         default: return $urandom();
      endcase
   endfunction

   // offer one body and hold it until accepted
   task automatic send_body(input logic [191:0] body);
      while (!calm && $urandom_range(99) < 24) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= body;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
   endtask

   task automatic send_axes(input logic [31:0] wx, wy, wz, dx, dy, dz);
      send_body({dz, dy, dx, wz, wy, wx});
   endtask

   initial begin
      n_sent = 0;
      all_sent = 0;
      calm = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, locked axes, momentum and torque overflow
      send_axes(0, 0, 0, 0, 0, 0);
      send_axes(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
      send_axes(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
      send_axes(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_axes(32'h8000_0000, 32'h0001_0000, 32'h0001_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_axes(32'h7fff_ffff, 32'h0001_0000, 32'h0001_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_axes(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 1);
      send_axes(32'hffff_ffff, 32'h0000_0001, 32'hffff_0000,
                32'h0000_0001, 0, 32'h0002_0000);
      send_axes(32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                32'h0000_0100, 32'h0000_0200, 32'h0001_0000);
      send_axes(32'h8000_0000, 32'h7fff_ffff, 0,
                32'h0001_0000, 32'h0002_0000, 0);
      send_axes(32'hfff0_0000, 32'h0010_0000, 32'h0000_8000,
                32'h8000_0000, 32'h0000_8000, 32'h0000_0001);
      send_axes(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678,
                32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a987);
      // random bodies, with a calm stretch in the middle
      for (int i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 400 && i < 480);
         send_axes(rand_omega(), rand_omega(), rand_omega(),
                   rand_inv(), rand_inv(), rand_inv());
      end
      calm = 0;
      req_tvalid <= 0;
      all_sent = 1;
   end

   // drain and report
   initial begin
      wait (all_sent);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("%0d bodies sent, %0d torque vectors checked (%0d valid, %0d overflowed)",
               n_sent, sb.n_checked, sb.n_ok, sb.n_overflow);
      $display("covered locked axes, field extremes, overflow and a long output stall");
      if (sb.n_bad == 0) begin
         $display("gyroscopic_torque_unit: match");
      end else begin
         $display("%0d mismatches", sb.n_bad);
         $display("gyroscopic_torque_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout");
      $display("gyroscopic_torque_unit: mismatch");
      $finish;
   end
endmodule
